### hdl/skhc_pkg.sv
package skhc_pkg;
	localparam int SLOTS = 4096;
	localparam int KEY_BYTES = 30;
	localparam int COUNT_BITS = 20;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int KLEN_W = $clog2(KEY_BYTES + 1);
	localparam int KIDX_W = $clog2(KEY_BYTES);
	localparam int TS_W = 13;
	localparam int NAME_W = 8 * KEY_BYTES;

	localparam logic [2:0] ST_NEW = 3'd0;
	localparam logic [2:0] ST_EXIST = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_LONG = 3'd3;
	localparam logic [2:0] ST_READ = 3'd4;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  key_byte;
		logic        key_last;
		logic [11:0] read_slot;
		logic [4:0]  read_byte_index;
	} req_t;

	typedef struct packed {
		logic [11:0] slot_index;
		logic [19:0] entry_count;
		logic [7:0]  name_byte;
		logic [2:0]  status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE, S_MOD, S_PROBE, S_WAIT, S_CHECK, S_NEXT, S_RDWAIT, S_RDOUT, S_DONE
	} state_t;
endpackage

### hdl/skhc_table.sv
// Name and count stores: one synchronous read port, one write port each.
module skhc_table import skhc_pkg::*; (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [SLOT_W-1:0]     rd_addr,
	output logic [NAME_W-1:0]     rd_name,
	output logic [COUNT_BITS-1:0] rd_count,
	input  logic                  wr_en,
	input  logic                  wr_name_en,
	input  logic [SLOT_W-1:0]     wr_addr,
	input  logic [NAME_W-1:0]     wr_name,
	input  logic [COUNT_BITS-1:0] wr_count
);
	logic [NAME_W-1:0]     name_mem [SLOTS];
	logic [COUNT_BITS-1:0] cnt_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cnt_mem[wr_addr] <= wr_count;
			if (wr_name_en) name_mem[wr_addr] <= wr_name;
		end
		if (rd_en) begin
			rd_name <= name_mem[rd_addr];
			rd_count <= cnt_mem[rd_addr];
		end
	end
endmodule

### hdl/string_key_hash_counter_top.sv
// A key byte that is not last gives no response; a read answers through S_RDWAIT and S_RDOUT.
// An insertion runs the modulo in S_MOD, then visits probe slots through S_PROBE, S_WAIT, S_CHECK and S_NEXT.
// Throughput: one request at a time (busy high while working); bytes go one per cycle while busy is low.
// After reset a clearing pass over all SLOTS slots zeroes the counts, busy stays high.
// Results show for one cycle with done; the receiver cannot stall.
module string_key_hash_counter_top import skhc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	output logic             done,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [TS_W-1:0]  cfg_wdata
);
	state_t state_q, state_n;
	logic [TS_W-1:0] table_size_q;
	logic [KEY_BYTES-1:0][7:0] kbuf_q;
	logic [KLEN_W-1:0] klen_q;
	logic [31:0] hash_q;
	logic kovf_q, kend_q;
	logic [SLOT_W:0] clr_q;
	logic clearing;
	// modulo: restoring remainder, one bit per cycle
	logic [31:0] mq_q;
	logic [TS_W:0] rem_q;
	logic [5:0] mcnt_q;
	logic [TS_W-1:0] ts_q;
	logic [SLOT_W-1:0] home_q, pos_q;
	logic [TS_W-1:0] step_q;   // probe count c
	logic [TS_W-1:0] dpos_q, dneg_q; // home +- k^2 mod ts, tracked incrementally
	logic [TS_W:0] odd_q;     // 2k+1 mod ts
	logic [SLOT_W-1:0] rslot_q;
	logic [KIDX_W-1:0] ridx_q;
	logic rslot_ok_q, ridx_ok_q;
	rsp_t rsp_q;
	logic done_q;

	logic rd_en, wr_en, wr_name_en;
	logic [SLOT_W-1:0] rd_addr, wr_addr;
	logic [NAME_W-1:0] rd_name;
	logic [COUNT_BITS-1:0] rd_count, wr_count;

	skhc_table u_tab (.clk, .rd_en, .rd_addr, .rd_name, .rd_count, .wr_en, .wr_name_en,
		.wr_addr, .wr_name(kbuf_q), .wr_count);

	assign clearing = !clr_q[SLOT_W];
	assign busy = clearing || state_q != S_IDLE;
	wire accept = start && !busy;
	wire [TS_W-1:0] eff_ts = (table_size_q == '0) ? TS_W'(1) :
		(table_size_q > TS_W'(SLOTS)) ? TS_W'(SLOTS) : table_size_q;
	wire [TS_W:0] rem_sh = {rem_q[TS_W-1:0], mq_q[31]};
	wire [TS_W:0] rem_nx = (rem_sh >= {1'b0, ts_q}) ? rem_sh - {1'b0, ts_q} : rem_sh;
	wire match = rd_name == NAME_W'(kbuf_q);
	wire [COUNT_BITS-1:0] cmax = '1;
	wire [COUNT_BITS-1:0] cinc = (rd_count == cmax) ? cmax : rd_count + 1'b1;
	// next k^2 offsets: add odd number mod ts
	wire [TS_W:0] dp_sum = {1'b0, dpos_q} + odd_q;
	wire [TS_W-1:0] dp_nx = (dp_sum >= {1'b0, ts_q}) ? TS_W'(dp_sum - {1'b0, ts_q}) :
		TS_W'(dp_sum);
	wire [TS_W:0] dn_dif = {1'b0, dneg_q} - odd_q;
	wire [TS_W-1:0] dn_nx = dn_dif[TS_W] ? TS_W'(dn_dif + {1'b0, ts_q}) : TS_W'(dn_dif);
	wire [TS_W:0] odd_sum = odd_q + 2'd2;
	wire [TS_W:0] odd_nx = (odd_sum >= {1'b0, ts_q}) ? odd_sum - {1'b0, ts_q} : odd_sum;
	wire [TS_W-1:0] step_nx = step_q + 1'b1;

	// next-state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: if (accept) begin
				if (req.req_type) state_n = S_RDWAIT;
				else if (req.key_last) state_n = S_MOD;
			end
			S_MOD: if (mcnt_q == 6'd31) state_n = S_PROBE;
			S_PROBE: state_n = S_WAIT;
			S_WAIT: state_n = S_CHECK;
			S_CHECK: state_n = S_NEXT;
			S_NEXT: state_n = S_PROBE;
			S_RDWAIT: state_n = S_RDOUT;
			S_RDOUT: state_n = S_IDLE;
			S_DONE: state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
		if (state_q == S_IDLE && accept && !req.req_type && req.key_last) begin
			if (kovf_q || (!kend_q && req.key_byte != 8'd0 && klen_q == KLEN_W'(KEY_BYTES)))
				state_n = S_DONE;
		end
		if (state_q == S_CHECK && (rd_count == '0 || match)) state_n = S_IDLE;
		if (state_q == S_NEXT && step_nx >= ts_q) state_n = S_IDLE;
	end

	// memory port control
	always_comb begin
		rd_en = (state_q == S_PROBE) || (state_q == S_IDLE && accept && req.req_type);
		rd_addr = (state_q == S_PROBE) ? pos_q : req.read_slot;
		wr_en = clearing || (state_q == S_CHECK && (rd_count == '0 || match));
		wr_name_en = !clearing && rd_count == '0;
		wr_addr = clearing ? clr_q[SLOT_W-1:0] : pos_q;
		wr_count = clearing ? '0 : cinc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			table_size_q <= TS_W'(4093);
			klen_q <= '0;
			hash_q <= '0;
			kovf_q <= 1'b0;
			kend_q <= 1'b0;
			clr_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q <= state_q == S_DONE || state_q == S_RDOUT ||
				(state_q == S_CHECK && (rd_count == '0 || match)) ||
				(state_q == S_NEXT && step_nx >= ts_q);
			if (clearing) clr_q <= clr_q + 1'b1;
			if (cfg_we) table_size_q <= cfg_wdata;
			if (state_q == S_IDLE && accept && !req.req_type) begin
				if (!kend_q) begin
					if (req.key_byte == 8'd0) kend_q <= 1'b1;
					else begin
						hash_q <= (hash_q << 5) + 32'(req.key_byte);
						if (klen_q < KLEN_W'(KEY_BYTES)) klen_q <= klen_q + 1'b1;
						else kovf_q <= 1'b1;
					end
				end
			end
			// key ends: registers back to reset when the modulo finishes or a too-long key is answered
			if ((state_q == S_MOD && mcnt_q == 6'd31) || state_q == S_DONE) begin
				klen_q <= '0;
				hash_q <= '0;
				kovf_q <= 1'b0;
				kend_q <= 1'b0;
			end
		end
	end

	// payload and datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			rslot_q <= req.read_slot;
			ridx_q <= KIDX_W'(req.read_byte_index);
			ridx_ok_q <= req.read_byte_index < 5'(KEY_BYTES);
			rslot_ok_q <= 32'(req.read_slot) < SLOTS;
			ts_q <= eff_ts;
			mq_q <= (kend_q || req.key_byte == 8'd0) ? hash_q :
				(hash_q << 5) + 32'(req.key_byte);
			rem_q <= '0;
			mcnt_q <= '0;
		end
		if (state_q == S_MOD) begin
			mq_q <= mq_q << 1;
			rem_q <= rem_nx;
			mcnt_q <= mcnt_q + 1'b1;
			if (mcnt_q == 6'd31) begin
				home_q <= SLOT_W'(rem_nx);
				pos_q <= SLOT_W'(rem_nx);
				dpos_q <= TS_W'(rem_nx);
				dneg_q <= TS_W'(rem_nx);
				odd_q <= (ts_q == TS_W'(1)) ? '0 : (TS_W+1)'(1);
				step_q <= '0;
			end
		end
		if (state_q == S_NEXT) begin
			step_q <= step_nx;
			if (!step_q[0]) begin
				dpos_q <= dp_nx;
				pos_q <= SLOT_W'(dp_nx);
			end else begin
				dneg_q <= dn_nx;
				pos_q <= SLOT_W'(dn_nx);
				odd_q <= odd_nx;
			end
		end
		if (state_q == S_DONE) rsp_q <= '{12'd0, 20'd0, 8'd0, ST_LONG};
		if (state_q == S_RDOUT)
			rsp_q <= '{rslot_q, rslot_ok_q ? 20'(rd_count) : 20'd0,
				(rslot_ok_q && ridx_ok_q) ? rd_name[ridx_q*8 +: 8] : 8'd0, ST_READ};
		if (state_q == S_CHECK) begin
			if (rd_count == '0) rsp_q <= '{12'(pos_q), 20'd1, 8'd0, ST_NEW};
			else rsp_q <= '{12'(pos_q), 20'(cinc), 8'd0, ST_EXIST};
		end
		if (state_q == S_NEXT && step_nx >= ts_q)
			rsp_q <= '{12'(home_q), 20'd0, 8'd0, ST_FULL};
		// key buffer: first byte of a key starts from zero; back to zero after insertion or a too-long key ends
		if ((state_q == S_CHECK && (rd_count == '0 || match)) ||
			(state_q == S_NEXT && step_nx >= ts_q) || state_q == S_DONE)
			kbuf_q <= '0;
		else if (state_q == S_IDLE && accept && !req.req_type) begin
			if (klen_q == '0)
				kbuf_q <= (!kend_q && req.key_byte != 8'd0) ? NAME_W'(req.key_byte) : '0;
			else if (!kend_q && req.key_byte != 8'd0 && klen_q < KLEN_W'(KEY_BYTES))
				kbuf_q[klen_q[KIDX_W-1:0]] <= req.key_byte;
		end
	end

	assign done = done_q;
	assign rsp = rsp_q;
endmodule

### hdl/skhc_checker.sv
module skhc_checker import skhc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);
	a_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == ST_NEW || rsp.status == ST_EXIST || rsp.status == ST_FULL
			|| rsp.status == ST_LONG || rsp.status == ST_READ))
		else $error("bad status");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_new_one: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_NEW) |-> rsp.entry_count == 20'd1)
		else $error("new count");
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && $past(1'b1)) |=> busy || !done) else $error("busy");
endmodule

bind string_key_hash_counter_top skhc_checker u_chk (.clk, .arst_n, .start, .busy,
	.done, .rsp);

### tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import skhc_pkg::*;

	// Software view of the hash counter: table contents, key being built,
	// and the responses still owed by the block.
	class KeyCountModel;
		bit [7:0]   names [SLOTS][KEY_BYTES];
		bit [19:0]  counts [SLOTS];
		bit         named [SLOTS];
		int         used_slots [$];
		bit [7:0]   kbuf [KEY_BYTES];
		int         klen;
		bit [31:0]  hash;
		bit         too_long;
		bit         ended;
		int         table_size = 4093;
		rsp_t       pending [$];
		int         errors;

		function void clear_key();
			foreach (kbuf[i]) kbuf[i] = 0;
			klen = 0;
			hash = 0;
			too_long = 0;
			ended = 0;
		endfunction

		function bit name_matches(int s);
			for (int i = 0; i < KEY_BYTES; i++)
				if (names[s][i] != kbuf[i]) return 0;
			return 1;
		endfunction

		function void note_request(req_t r);
			rsp_t   x;
			longint ts, home, pos, k, d;
			x = '0;
			if (r.req_type) begin
				x.slot_index = r.read_slot;
				x.entry_count = counts[r.read_slot];
				if (r.read_byte_index < KEY_BYTES)
					x.name_byte = names[r.read_slot][r.read_byte_index];
				x.status = ST_READ;
				pending.push_back(x);
				return;
			end
			if (!ended) begin
				if (r.key_byte == 0) ended = 1;
				else begin
					hash = (hash << 5) + r.key_byte;
					if (klen < KEY_BYTES) kbuf[klen++] = r.key_byte;
					else too_long = 1;
				end
			end
			if (!r.key_last) return;
			if (too_long) begin
				x.status = ST_LONG;
				pending.push_back(x);
				clear_key();
				return;
			end
			ts = (table_size == 0) ? 1 : (table_size > SLOTS) ? SLOTS : table_size;
			home = hash % ts;
			pos = home;
			x.status = ST_FULL;
			x.slot_index = home;
			for (longint c = 0; c < ts; c++) begin
				if (c != 0) begin
					// alternate +k^2 / -k^2 around the home slot
					k = (c & 1) ? (c + 1) / 2 : c / 2;
					d = (k * k) % ts;
					pos = (c & 1) ? (home + d) % ts : (home + ts - d) % ts;
				end
				if (counts[pos] == 0) begin
					foreach (kbuf[i]) names[pos][i] = kbuf[i];
					counts[pos] = 1;
					if (!named[pos]) used_slots.push_back(pos);
					named[pos] = 1;
					x.slot_index = pos;
					x.entry_count = 1;
					x.status = ST_NEW;
					break;
				end
				if (name_matches(pos)) begin
					if (counts[pos] != '1) counts[pos]++;
					x.slot_index = pos;
					x.entry_count = counts[pos];
					x.status = ST_EXIST;
					break;
				end
			end
			pending.push_back(x);
			clear_key();
		endfunction

		function void check_result(rsp_t r);
			rsp_t e;
			if (pending.size() == 0) begin
				$error("unexpected response slot %0d status %0d", r.slot_index, r.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (r.slot_index != e.slot_index) begin
				$error("slot_index exp %0d got %0d", e.slot_index, r.slot_index);
				errors++;
			end
			if (r.entry_count != e.entry_count) begin
				$error("entry_count exp %0d got %0d", e.entry_count, r.entry_count);
				errors++;
			end
			if (r.name_byte != e.name_byte) begin
				$error("name_byte exp %0d got %0d", e.name_byte, r.name_byte);
				errors++;
			end
			if (r.status != e.status) begin
				$error("status exp %0d got %0d", e.status, r.status);
				errors++;
			end
		endfunction

		// Read of a slot: a written slot at any byte, or any slot at an
		// out-of-range byte index (never-written names are not read).
		function req_t pick_read();
			req_t r;
			r = req_t'({$urandom, $urandom});
			r.req_type = 1;
			if (used_slots.size() != 0 && $urandom_range(0, 4) != 0) begin
				r.read_slot = used_slots[$urandom_range(0, used_slots.size() - 1)];
				r.read_byte_index = $urandom_range(0, KEY_BYTES - 1);
			end else begin
				r.read_slot = $urandom_range(0, SLOTS - 1);
				r.read_byte_index = $urandom_range(KEY_BYTES, 31);
			end
			return r;
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	req_t            req;
	logic            done;
	rsp_t            rsp;
	logic            cfg_we;
	logic [TS_W-1:0] cfg_wdata;

	KeyCountModel    model;
	bit              quiet;
	bit [7:0]        words [16][KEY_BYTES];
	int              word_len [16];

	string_key_hash_counter_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Responses last one cycle and cannot be held off: sample every edge.
	always @(posedge clk) begin
		if (arst_n && done) model.check_result(rsp);
	end

	task automatic pause(int n);
		start <= 0;
		repeat (n) @(posedge clk);
	endtask

	// Drive one request and hold it until the block takes it. start stays
	// high on return so back-to-back requests need no gap.
	task automatic send(req_t r);
		if (!quiet && $urandom_range(0, 5) == 0) pause($urandom_range(1, 11));
		start <= 1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		model.note_request(r);
	endtask

	task automatic send_read();
		send(model.pick_read());
	endtask

	// Key as byte sequence; n == 0 sends the empty key (a lone zero byte).
	// Unused read fields carry random junk, and reads may slip in mid-key.
	task automatic send_key(bit [7:0] b [40], int n, bit mix_reads);
		req_t r;
		int   last_i;
		last_i = (n == 0) ? 0 : n - 1;
		for (int i = 0; i <= last_i; i++) begin
			if (mix_reads && $urandom_range(0, 9) == 0) send_read();
			r = req_t'({$urandom, $urandom});
			r.req_type = 0;
			r.key_byte = (n == 0) ? 8'd0 : b[i];
			r.key_last = (i == last_i);
			send(r);
		end
	endtask

	// Wait until every owed response is in, then let the block settle.
	task automatic drain();
		start <= 0;
		while (model.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic set_table_size(logic [TS_W-1:0] v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		model.table_size = v;
	endtask

	task automatic send_word(int w, bit mix_reads);
		bit [7:0] b [40];
		foreach (words[w][i]) b[i] = words[w][i];
		send_key(b, word_len[w], mix_reads);
	endtask

	task automatic directed();
		bit [7:0] b [40];
		send_key(b, 0, 0);                        // empty key
		send_key(b, 0, 0);                        // empty again: existing
		send_word(0, 0);
		send_word(0, 0);
		send_word(1, 0);                          // full-length key, 0xFF bytes
		for (int i = 0; i < 31; i++) b[i] = 8'h41 + i;
		send_key(b, 31, 0);                       // one byte too long
		// zero byte ends the text: same key as word 0 with junk behind it
		foreach (words[0][i]) b[i] = words[0][i];
		b[word_len[0]] = 0;
		b[word_len[0] + 1] = 8'h80;
		b[word_len[0] + 2] = 8'h7F;
		send_key(b, word_len[0] + 3, 0);
		b[0] = 8'h01; b[1] = 8'h80; b[2] = 8'hFF;
		send_key(b, 3, 0);
		for (int i = 0; i < 6; i++) send_read();
	endtask

	// Mostly vocabulary keys (repeats drive existing/full paths), some long
	// keys, keys broken by a zero byte, reads, and short random keys.
	task automatic random_phase(int budget);
		bit [7:0] b [40];
		int       n, w;
		for (int k = 0; k < budget; k++) begin
			n = $urandom_range(0, 99);
			if (n < 55) send_word($urandom_range(0, 15), 1);
			else if (n < 63) begin
				n = $urandom_range(KEY_BYTES + 1, 40);
				foreach (b[i]) b[i] = $urandom_range(1, 255);
				send_key(b, n, 1);
			end else if (n < 73) begin
				w = $urandom_range(0, 15);
				foreach (b[i]) b[i] = $urandom;
				foreach (words[w][i]) if (i < word_len[w]) b[i] = words[w][i];
				b[$urandom_range(0, word_len[w])] = 0;
				send_key(b, $urandom_range(1, 40), 1);
			end else if (n < 90) send_read();
			else begin
				foreach (b[i]) b[i] = $urandom;
				send_key(b, $urandom_range(1, 6), 1);
			end
		end
	endtask

	initial begin
		model = new();
		arst_n = 0;
		start = 0;
		req = '0;
		cfg_we = 0;
		cfg_wdata = '0;
		for (int w = 0; w < 16; w++) begin
			word_len[w] = $urandom_range(1, KEY_BYTES);
			foreach (words[w][i]) words[w][i] = (i < word_len[w]) ? $urandom_range(1, 255) : 0;
		end
		word_len[0] = 5;
		word_len[1] = KEY_BYTES;
		foreach (words[1][i]) words[1][i] = 8'hFF;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// reset size 4093 first; the block clears its counts before taking work
		directed();
		random_phase(6);
		set_table_size(7);                        // small: fills up, table full
		random_phase(6);
		// pause the sender until the block has answered everything
		drain();
		random_phase(4);
		set_table_size(1);
		random_phase(4);
		set_table_size(0);                        // acts as one slot
		random_phase(4);
		set_table_size(13'h1FFF);                 // above range: all slots
		random_phase(6);
		set_table_size(2);
		random_phase(4);
		set_table_size(13);
		random_phase(6);
		set_table_size(4096);
		quiet = 1;                                // no idling at the tail
		random_phase(6);
		for (int i = 0; i < 6; i++) send_read();
		drain();

		if (model.errors == 0)
			$display("string_key_hash_counter_top test passed");
		else
			$display("string_key_hash_counter_top test failed");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("string_key_hash_counter_top test failed");
		$finish;
	end
endmodule
